/* hw/rtl/btr_pkg.sv */
// btr_pkg: shared types, constants and helpers of the bitmap text rasterizer
// used by btr_front, btr_fifo, btr_back and bitmap_text_rasterizer
// no dependencies
`default_nettype none

package btr_pkg;

  // display and font geometry
  localparam int unsigned DISPLAY_WIDTH   = 640;
  localparam int unsigned DISPLAY_HEIGHT  = 480;
  localparam int unsigned MAX_GLYPH_WIDTH = 8;
  localparam int unsigned FONT_DEPTH      = 2048;
  localparam int unsigned FONT_AW         = $clog2(FONT_DEPTH);

  // special character codes
  localparam logic [7:0] CODE_CR = 8'd13;
  localparam logic [7:0] CODE_LF = 8'd10;

  // configuration register indexes
  localparam logic [2:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] CFG_SCALE        = 3'd2;
  localparam logic [2:0] CFG_CHAR_GAP     = 3'd3;
  localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd5;

  // result kinds
  localparam logic KIND_SQUARE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_CHAR  = 2'd2,
    MODE_END   = 2'd3
  } mode_e;

  // classified request held in the queue
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_START,
    OP_CHAR,
    OP_NEWLINE,
    OP_END
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FLUSH,
    ST_REPORT
  } back_state_e;

  typedef struct packed {
    mode_e      mode;
    logic [10:0] font_addr;
    logic [7:0] font_byte;
    logic [7:0] char_code;
    logic       next_is_lf;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [3:0]  block_size;
    logic [15:0] end_y;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [3:0]  scale;
    logic [3:0]  char_gap;
    logic [3:0]  glyph_width;
    logic [3:0]  glyph_height;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [FONT_AW-1:0] addr;   // load address or glyph base address
    logic [7:0]         data;   // font byte for loads
    logic               is_lf;  // character code is line feed
  } cmd_t;

  // clamp a 4-bit register value into 1..hi
  function automatic logic [3:0] clamp_1(input logic [3:0] v, input logic [3:0] hi);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // saturate a 17-bit sum to 16 bits
  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/btr_front.sv */
// btr_front: accepts input requests and classifies them into queue commands
// depends on btr_pkg
`default_nettype none

module btr_front (
  input  wire btr_pkg::in_item_t in_data_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire btr_pkg::cfg_t     cfg_i,
  input  wire                    q_full_i,
  output logic                   q_push_o,
  output btr_pkg::cmd_t          q_cmd_o
);

  logic [3:0]                  gw_eff;
  logic [btr_pkg::FONT_AW-1:0] glyph_base;

  // glyph base address, taken modulo the font depth
  assign gw_eff     = btr_pkg::clamp_1(cfg_i.glyph_width, 4'(btr_pkg::MAX_GLYPH_WIDTH));
  assign glyph_base = btr_pkg::FONT_AW'(in_data_i.char_code) * btr_pkg::FONT_AW'(gw_eff);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // request classification
  always_comb begin
    q_cmd_o.addr  = glyph_base;
    q_cmd_o.data  = in_data_i.font_byte;
    q_cmd_o.is_lf = (in_data_i.char_code == btr_pkg::CODE_LF);
    q_cmd_o.op    = btr_pkg::OP_CHAR;
    unique case (in_data_i.mode)
      btr_pkg::MODE_LOAD: begin
        q_cmd_o.op   = btr_pkg::OP_LOAD;
        q_cmd_o.addr = in_data_i.font_addr;
      end
      btr_pkg::MODE_START: q_cmd_o.op = btr_pkg::OP_START;
      btr_pkg::MODE_CHAR: begin
        if (in_data_i.char_code == btr_pkg::CODE_CR && in_data_i.next_is_lf) begin
          q_cmd_o.op = btr_pkg::OP_NEWLINE;
        end else begin
          q_cmd_o.op = btr_pkg::OP_CHAR;
        end
      end
      btr_pkg::MODE_END: q_cmd_o.op = btr_pkg::OP_END;
      default: q_cmd_o.op = btr_pkg::OP_CHAR;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/btr_fifo.sv */
// btr_fifo: two-entry command queue between front and back
// depends on btr_pkg
`default_nettype none

module btr_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire btr_pkg::cmd_t  cmd_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                empty_o,
  output btr_pkg::cmd_t       cmd_o
);

  btr_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
      count_d  = count_d + 2'd1;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
      count_d  = count_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/btr_back.sv */
// btr_back: font store, cursor state and the square sequencer
// depends on btr_pkg
`default_nettype none

module btr_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire btr_pkg::cfg_t   cfg_i,
  input  wire                  q_empty_i,
  input  wire btr_pkg::cmd_t   q_cmd_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output btr_pkg::out_item_t   out_data_o
);

  // font store
  logic [7:0]                  font_mem [btr_pkg::FONT_DEPTH];
  logic [7:0]                  rdata_q;
  logic [btr_pkg::FONT_AW-1:0] raddr;
  logic                        mem_we;

  btr_pkg::back_state_e        state_q, state_d;
  logic [15:0]                 cur_x_q, cur_x_d;
  logic [15:0]                 cur_y_q, cur_y_d;
  logic                        skip_lf_q, skip_lf_d;
  logic [btr_pkg::FONT_AW-1:0] base_q, base_d;
  logic [2:0]                  cx_q, cx_d;
  logic [7:0]                  mask_q, mask_d;
  logic                        first_q, first_d;
  logic                        pend_v_q, pend_v_d;
  btr_pkg::out_item_t          pend_q, pend_d;
  logic                        out_valid_q, out_valid_d;
  btr_pkg::out_item_t          out_q, out_d;

  logic [3:0]  s_eff, gw_eff, gh_eff;
  logic [7:0]  h_mask, cur_mask;
  logic [7:0]  line_step, advance;
  logic [2:0]  bit_idx;
  logic [6:0]  col_off, row_off;
  logic [15:0] sq_x, sq_y, x_adv, y_line;
  logic        out_free;
  btr_pkg::out_item_t square;

  // effective geometry
  assign s_eff     = btr_pkg::clamp_1(cfg_i.scale, 4'd8);
  assign gw_eff    = btr_pkg::clamp_1(cfg_i.glyph_width, 4'(btr_pkg::MAX_GLYPH_WIDTH));
  assign gh_eff    = btr_pkg::clamp_1(cfg_i.glyph_height, 4'd8);
  assign h_mask    = 8'hFF >> (4'd8 - gh_eff);
  assign line_step = (8'(gh_eff) + 8'(cfg_i.char_gap)) * 8'(s_eff);
  assign advance   = (8'(gw_eff) + 8'(cfg_i.char_gap)) * 8'(s_eff);
  assign x_adv     = btr_pkg::sat16(17'(cur_x_q) + 17'(advance));
  assign y_line    = btr_pkg::sat16(17'(cur_y_q) + 17'(line_step));

  // column bits still to draw, highest glyph bit first
  assign cur_mask = first_q ? (rdata_q & h_mask) : mask_q;

  always_comb begin
    bit_idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (cur_mask[i]) bit_idx = 3'(i);
    end
  end

  // square for the selected bit
  assign col_off = 7'(cx_q) * 7'(s_eff);
  assign row_off = 7'(bit_idx) * 7'(s_eff);
  assign sq_x    = btr_pkg::sat16(17'(cur_x_q) + 17'(col_off));
  assign sq_y    = btr_pkg::sat16(17'(cur_y_q) + 17'(row_off));

  always_comb begin
    square.kind       = btr_pkg::KIND_SQUARE;
    square.pixel_x    = sq_x;
    square.pixel_y    = sq_y;
    square.block_size = s_eff;
    square.end_y      = 16'd0;
    square.last       = 1'b0;
  end

  assign raddr    = base_q + btr_pkg::FONT_AW'(cx_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    skip_lf_d   = skip_lf_q;
    base_d      = base_q;
    cx_d        = cx_q;
    mask_d      = mask_q;
    first_d     = first_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    unique case (state_q)
      btr_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          unique case (q_cmd_i.op)
            btr_pkg::OP_LOAD: mem_we = 1'b1;
            btr_pkg::OP_START: begin
              cur_x_d   = 16'(cfg_i.origin_x);
              cur_y_d   = 16'(cfg_i.origin_y);
              skip_lf_d = 1'b0;
            end
            btr_pkg::OP_NEWLINE: begin
              cur_x_d   = 16'(cfg_i.origin_x);
              cur_y_d   = (y_line > 16'(btr_pkg::DISPLAY_HEIGHT)) ?
                          16'(cfg_i.origin_y) : y_line;
              skip_lf_d = 1'b1;
            end
            btr_pkg::OP_CHAR: begin
              skip_lf_d = 1'b0;
              if (!(skip_lf_q && q_cmd_i.is_lf)) begin
                base_d  = q_cmd_i.addr;
                cx_d    = 3'd0;
                state_d = btr_pkg::ST_READ;
              end
            end
            btr_pkg::OP_END: state_d = btr_pkg::ST_REPORT;
            default: ;
          endcase
        end
      end
      btr_pkg::ST_READ: begin
        first_d = 1'b1;
        state_d = btr_pkg::ST_SCAN;
      end
      btr_pkg::ST_SCAN: begin
        if (cur_mask == 8'd0) begin
          first_d = 1'b0;
          if (cx_q == 3'(gw_eff - 4'd1)) begin
            state_d = btr_pkg::ST_FLUSH;
          end else begin
            cx_d    = cx_q + 3'd1;
            state_d = btr_pkg::ST_READ;
          end
        end else begin
          first_d = 1'b0;
          mask_d  = cur_mask;
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_v_d = 1'b1;
            pend_d   = square;
            mask_d   = cur_mask & ~(8'd1 << bit_idx);
          end
        end
      end
      btr_pkg::ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_d.last  = 1'b1;
            pend_v_d    = 1'b0;
          end
          if (x_adv > 16'(btr_pkg::DISPLAY_WIDTH)) begin
            cur_x_d = 16'(cfg_i.origin_x);
            cur_y_d = y_line;
          end else begin
            cur_x_d = x_adv;
          end
          state_d = btr_pkg::ST_IDLE;
        end
      end
      btr_pkg::ST_REPORT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.kind       = btr_pkg::KIND_END;
          out_d.pixel_x    = 16'd0;
          out_d.pixel_y    = 16'd0;
          out_d.block_size = 4'd0;
          out_d.end_y      = y_line;
          out_d.last       = 1'b1;
          state_d          = btr_pkg::ST_IDLE;
        end
      end
      default: state_d = btr_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btr_pkg::ST_IDLE;
      cur_x_q     <= 16'd0;
      cur_y_q     <= 16'd0;
      skip_lf_q   <= 1'b0;
      first_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      skip_lf_q   <= skip_lf_d;
      first_q     <= first_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    cx_q   <= cx_d;
    mask_q <= mask_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // font store ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[q_cmd_i.addr] <= q_cmd_i.data;
    end
    rdata_q <= font_mem[raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/bitmap_text_rasterizer.sv */
// bitmap_text_rasterizer: character generator top level with config registers
// depends on btr_pkg, btr_front, btr_fifo and btr_back
//
// usage: requests enter on in_valid_i/in_data_i and are taken when in_stall_o
// is low; results leave on out_valid_o/out_data_o and are held while
// out_stall_i is high. load requests fill the font store, start resets the
// cursor to the origin, character requests give one square per set glyph
// bit (last marks the final one), end requests give one end report.
// a two-entry queue decouples request intake from the drawing sequencer, so
// requests keep being taken, until it is full, while a result waits at the output.
// path: an end report passes the queue, the idle and report states and the
// output register; the first square of a character passes the queue, the
// read and scan states and the pending and output registers, and comes later
// behind blank leading columns or requests already queued. the sequencer takes
// each request in its idle state, an end request also in its report state; a
// character adds a read and a scan step per glyph column (single font store
// read port), a scan step per square and a flush step before the next request.
// a stalled output freezes the sequencer once its pending square is held.
// reset sets cursor, line feed flag, queue, config and control registers to
// their defaults; the font store is not cleared and must be loaded before use.
// the user must write configuration on cfg_we_i only while the block is idle; the block does not enforce this.
`default_nettype none

module bitmap_text_rasterizer (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire btr_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output btr_pkg::out_item_t      out_data_o,
  input  wire                     cfg_we_i,
  input  wire [2:0]               cfg_idx_i,
  input  wire [11:0]              cfg_wdata_i
);

  btr_pkg::cfg_t cfg_q, cfg_d;
  btr_pkg::cmd_t push_cmd, head_cmd;
  logic          q_push, q_pop, q_full, q_empty;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        btr_pkg::CFG_ORIGIN_X:     cfg_d.origin_x     = cfg_wdata_i;
        btr_pkg::CFG_ORIGIN_Y:     cfg_d.origin_y     = cfg_wdata_i;
        btr_pkg::CFG_SCALE:        cfg_d.scale        = cfg_wdata_i[3:0];
        btr_pkg::CFG_CHAR_GAP:     cfg_d.char_gap     = cfg_wdata_i[3:0];
        btr_pkg::CFG_GLYPH_WIDTH:  cfg_d.glyph_width  = cfg_wdata_i[3:0];
        btr_pkg::CFG_GLYPH_HEIGHT: cfg_d.glyph_height = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x     <= 12'd0;
      cfg_q.origin_y     <= 12'd0;
      cfg_q.scale        <= 4'd1;
      cfg_q.char_gap     <= 4'd1;
      cfg_q.glyph_width  <= 4'd5;
      cfg_q.glyph_height <= 4'd7;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // request intake
  btr_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  // command queue
  btr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  // drawing sequencer
  btr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
